// ----- rtl/owbm_pkg.sv -----
// owbm_pkg: shared types, constants and slot timing helpers for the 1-wire bus master
// used by every module of the block; depends on nothing
package owbm_pkg;

  // width of the per-phase tick counter
  localparam int TICK_COUNT_BITS = 10;
  // width of one timing register
  localparam int CFG_W = 10;
  // phase length needs to hold 2^TICK_COUNT_BITS itself
  localparam int LEN_W = (TICK_COUNT_BITS + 1 > CFG_W) ? TICK_COUNT_BITS + 1 : CFG_W;
  localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(2 ** TICK_COUNT_BITS);

  // request queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // register indexes
  localparam logic [2:0] REG_RESET_LOW      = 3'd0;
  localparam logic [2:0] REG_PRESENCE_WAIT  = 3'd1;
  localparam logic [2:0] REG_RESET_RECOVERY = 3'd2;
  localparam logic [2:0] REG_SHORT_LOW      = 3'd3;
  localparam logic [2:0] REG_WRITE_ONE_HIGH = 3'd4;
  localparam logic [2:0] REG_WRITE_ZERO_LOW = 3'd5;
  localparam logic [2:0] REG_READ_SAMPLE    = 3'd6;
  localparam logic [2:0] REG_READ_RECOVERY  = 3'd7;

  // opcodes on the request channel
  localparam logic [2:0] OP_NONE   = 3'd0;
  localparam logic [2:0] OP_RESET  = 3'd1;
  localparam logic [2:0] OP_WRITE  = 3'd2;
  localparam logic [2:0] OP_READ   = 3'd3;
  localparam logic [2:0] OP_WAIT   = 3'd4;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_RESET,
    CMD_WRITE,
    CMD_READ,
    CMD_WAIT
  } cmd_kind_t;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_RST_LOW,
    PH_RST_WAIT,
    PH_RST_SAMPLE,
    PH_RST_REC,
    PH_W1_LOW,
    PH_W1_HIGH,
    PH_W0_LOW,
    PH_RD_LOW,
    PH_RD_WAIT,
    PH_RD_SAMPLE,
    PH_RD_REC,
    PH_WAIT_REL
  } phase_t;

  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] data_byte;
    logic       line_level;
  } in_item_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_byte;
    logic       cmd_ignored;
  } out_item_t;

  typedef struct packed {
    cmd_kind_t  cmd;
    logic [7:0] data_byte;
    logic       line_level;
  } q_entry_t;

  typedef struct packed {
    logic [CFG_W-1:0] reset_low_ticks;
    logic [CFG_W-1:0] presence_wait_ticks;
    logic [CFG_W-1:0] reset_recovery_ticks;
    logic [CFG_W-1:0] short_low_ticks;
    logic [CFG_W-1:0] write_one_high_ticks;
    logic [CFG_W-1:0] write_zero_low_ticks;
    logic [CFG_W-1:0] read_sample_ticks;
    logic [CFG_W-1:0] read_recovery_ticks;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    reset_low_ticks:      CFG_W'(60),
    presence_wait_ticks:  CFG_W'(8),
    reset_recovery_ticks: CFG_W'(51),
    short_low_ticks:      CFG_W'(22),
    write_one_high_ticks: CFG_W'(70),
    write_zero_low_ticks: CFG_W'(80),
    read_sample_ticks:    CFG_W'(86),
    read_recovery_ticks:  CFG_W'(62)
  };

  // register value to phase length: optional floor of one, cap at counter range
  function automatic logic [LEN_W-1:0] eff_len(input logic [CFG_W-1:0] v,
                                               input logic at_least_one);
    logic [LEN_W-1:0] x;
    x = LEN_W'(v);
    if (at_least_one && (v == '0)) begin
      x = LEN_W'(1);
    end
    if (x > LEN_CAP) begin
      x = LEN_CAP;
    end
    return x;
  endfunction

  // ticks spent in a phase
  function automatic logic [LEN_W-1:0] phase_len(input phase_t p, input cfg_t c);
    logic [LEN_W-1:0] len;
    case (p)
      PH_RST_LOW:  len = eff_len(c.reset_low_ticks, 1'b1);
      PH_RST_WAIT: len = eff_len(c.presence_wait_ticks, 1'b1);
      PH_RST_REC:  len = eff_len(c.reset_recovery_ticks, 1'b0);
      PH_W1_LOW:   len = eff_len(c.short_low_ticks, 1'b1);
      PH_W1_HIGH:  len = eff_len(c.write_one_high_ticks, 1'b0);
      PH_W0_LOW:   len = eff_len(c.write_zero_low_ticks, 1'b1);
      PH_RD_LOW:   len = eff_len(c.short_low_ticks, 1'b1);
      PH_RD_WAIT:  len = eff_len(c.read_sample_ticks, 1'b0);
      PH_RD_REC:   len = eff_len(c.read_recovery_ticks, 1'b0);
      default:     len = LEN_W'(1);
    endcase
    return len;
  endfunction

endpackage

// ----- rtl/owbm_front.sv -----
// owbm_front: takes requests and classifies the opcode into a command kind
// depends on owbm_pkg; feeds owbm_queue
module owbm_front import owbm_pkg::*; (
  input  logic     cmd_valid,
  output logic     cmd_stall,
  input  in_item_t cmd,
  input  logic     q_full,
  output logic     q_push,
  output q_entry_t q_wdata
);

  // stall only when the queue has no room
  assign cmd_stall = q_full;
  assign q_push    = cmd_valid && !q_full;

  // opcode decode, unused codes act as no command
  always_comb begin
    q_wdata.data_byte  = cmd.data_byte;
    q_wdata.line_level = cmd.line_level;
    case (cmd.opcode)
      OP_RESET: q_wdata.cmd = CMD_RESET;
      OP_WRITE: q_wdata.cmd = CMD_WRITE;
      OP_READ:  q_wdata.cmd = CMD_READ;
      OP_WAIT:  q_wdata.cmd = CMD_WAIT;
      default:  q_wdata.cmd = CMD_NONE;
    endcase
  end

endmodule

// ----- rtl/owbm_queue.sv -----
// owbm_queue: short request queue between the front and the bus engine
// depends on owbm_pkg
module owbm_queue import owbm_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  q_entry_t wdata,
  output logic     full,
  input  logic     pop,
  output logic     not_empty,
  output q_entry_t rdata
);

  q_entry_t            mem [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;

  assign full      = (count == QCNT_W'(QDEPTH));
  assign not_empty = (count != '0);
  assign rdata     = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

// ----- rtl/owbm_engine.sv -----
// owbm_engine: bus phase sequencer with result register; one queued tick per cycle
// unless the result stalls; depends on owbm_pkg; reads requests from owbm_queue
module owbm_engine import owbm_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      q_valid,
  input  q_entry_t  q_head,
  output logic      q_pop,
  output logic      res_valid,
  input  logic      res_stall,
  output out_item_t res
);

  typedef struct packed {
    phase_t     phase;
    logic [2:0] bit_index;
    logic [7:0] shift_byte;
    logic [7:0] last_read;
    logic       finished;
  } step_t;

  // end of a phase: side effects and the phase that follows
  function automatic step_t after_phase(input step_t s_in, input logic line);
    step_t s;
    s = s_in;
    case (s.phase)
      PH_RST_LOW:    s.phase = PH_RST_WAIT;
      PH_RST_WAIT:   s.phase = PH_RST_SAMPLE;
      PH_RST_SAMPLE: s.phase = line ? PH_RST_LOW : PH_RST_REC;
      PH_W1_LOW:     s.phase = PH_W1_HIGH;
      PH_W1_HIGH, PH_W0_LOW: begin
        s.shift_byte = {1'b0, s.shift_byte[7:1]};
        if (s.bit_index == 3'd7) begin
          s.phase    = PH_IDLE;
          s.finished = 1'b1;
        end else begin
          s.bit_index = s.bit_index + 3'd1;
          s.phase     = s.shift_byte[0] ? PH_W1_LOW : PH_W0_LOW;
        end
      end
      PH_RD_LOW:     s.phase = PH_RD_WAIT;
      PH_RD_WAIT:    s.phase = PH_RD_SAMPLE;
      PH_RD_SAMPLE: begin
        s.shift_byte = {line, s.shift_byte[7:1]};
        s.phase      = PH_RD_REC;
      end
      PH_RD_REC: begin
        if (s.bit_index == 3'd7) begin
          s.last_read = s.shift_byte;
          s.phase     = PH_IDLE;
          s.finished  = 1'b1;
        end else begin
          s.bit_index = s.bit_index + 3'd1;
          s.phase     = PH_RD_LOW;
        end
      end
      default: begin
        s.phase    = PH_IDLE;
        s.finished = 1'b1;
      end
    endcase
    return s;
  endfunction

  phase_t                     phase;
  logic [TICK_COUNT_BITS-1:0] tick_count;
  logic [2:0]                 bit_index;
  logic [7:0]                 shift_byte;
  logic [7:0]                 last_read;

  step_t                      st;
  phase_t                     p0;
  logic [TICK_COUNT_BITS-1:0] tick_next;
  logic [LEN_W-1:0]           tick_inc;
  logic                       ignored;
  logic                       busy;
  logic                       drive;

  // pop a tick whenever the result register can take its result
  assign q_pop = q_valid && (!res_valid || !res_stall);

  // one tick of the bus sequencer
  always_comb begin
    st.phase      = phase;
    st.bit_index  = bit_index;
    st.shift_byte = shift_byte;
    st.last_read  = last_read;
    st.finished   = 1'b0;
    tick_next     = tick_count;
    ignored       = 1'b0;
    tick_inc      = '0;

    // command start, or drop when busy
    if (q_head.cmd != CMD_NONE) begin
      if (phase != PH_IDLE) begin
        ignored = 1'b1;
      end else begin
        tick_next    = '0;
        st.bit_index = '0;
        case (q_head.cmd)
          CMD_RESET: st.phase = PH_RST_LOW;
          CMD_WRITE: begin
            st.shift_byte = q_head.data_byte;
            st.phase      = q_head.data_byte[0] ? PH_W1_LOW : PH_W0_LOW;
          end
          CMD_READ: begin
            st.shift_byte = '0;
            st.phase      = PH_RD_LOW;
          end
          default: st.phase = PH_WAIT_REL;
        endcase
      end
    end

    p0    = st.phase;
    busy  = (p0 != PH_IDLE);
    drive = (p0 == PH_RST_LOW) || (p0 == PH_W1_LOW) ||
            (p0 == PH_W0_LOW) || (p0 == PH_RD_LOW);

    // timing and phase advance, zero-length phases are skipped
    if (p0 == PH_WAIT_REL) begin
      if (q_head.line_level) begin
        st.phase    = PH_IDLE;
        st.finished = 1'b1;
      end
    end else if (p0 != PH_IDLE) begin
      tick_inc = LEN_W'(tick_next) + LEN_W'(1);
      if (tick_inc >= phase_len(p0, cfg)) begin
        tick_next = '0;
        st = after_phase(st, q_head.line_level);
        if ((st.phase != PH_IDLE) && (phase_len(st.phase, cfg) == '0)) begin
          st = after_phase(st, q_head.line_level);
        end
      end else begin
        tick_next = tick_inc[TICK_COUNT_BITS-1:0];
      end
    end
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      tick_count <= '0;
      bit_index  <= '0;
      shift_byte <= '0;
      last_read  <= '0;
    end else if (q_pop) begin
      phase      <= st.phase;
      tick_count <= tick_next;
      bit_index  <= st.bit_index;
      shift_byte <= st.shift_byte;
      last_read  <= st.last_read;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (q_pop) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      res.drive_low   <= drive;
      res.busy_res    <= busy;
      res.done_res    <= st.finished;
      res.read_byte   <= st.last_read;
      res.cmd_ignored <= ignored;
    end
  end

endmodule

// ----- rtl/one_wire_bus_master_core.sv -----
// one_wire_bus_master_core: 1-wire bus master, one request per 1 us tick, one result per tick
// throughput: one request and one sequencer tick per cycle, while the result is not stalled
// path: a taken request waits in a queue slot, then its result is held in the result register
// reset (rst, synchronous): bus idle, counters and read byte cleared, timing registers to defaults
// depends on owbm_pkg, owbm_front, owbm_queue, owbm_engine
module one_wire_bus_master_core import owbm_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_valid,
  output logic             cmd_stall,
  input  in_item_t         cmd,
  output logic             res_valid,
  input  logic             res_stall,
  output out_item_t        res,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [2:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  cfg_t     cfg;
  logic     q_full;
  logic     q_push;
  q_entry_t q_wdata;
  logic     q_pop;
  logic     q_valid;
  q_entry_t q_head;

  assign cfg_ready = 1'b1;

  // timing registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_RESET_LOW:      cfg.reset_low_ticks      <= cfg_data;
        REG_PRESENCE_WAIT:  cfg.presence_wait_ticks  <= cfg_data;
        REG_RESET_RECOVERY: cfg.reset_recovery_ticks <= cfg_data;
        REG_SHORT_LOW:      cfg.short_low_ticks      <= cfg_data;
        REG_WRITE_ONE_HIGH: cfg.write_one_high_ticks <= cfg_data;
        REG_WRITE_ZERO_LOW: cfg.write_zero_low_ticks <= cfg_data;
        REG_READ_SAMPLE:    cfg.read_sample_ticks    <= cfg_data;
        REG_READ_RECOVERY:  cfg.read_recovery_ticks  <= cfg_data;
        default:            cfg <= cfg;
      endcase
    end
  end

  // request intake and decode
  owbm_front u_front (
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  // decoupling queue
  owbm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .wdata     (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .rdata     (q_head)
  );

  // bus engine and result register
  owbm_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  // a finishing tick is always a busy tick
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (!res.done_res || res.busy_res))
    else $error("done without busy");

  // a dropped command only happens while a command runs
  a_ignored_busy: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (!res.cmd_ignored || res.busy_res))
    else $error("command dropped while idle");

  // bus is only pulled low during a command
  a_drive_busy: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (!res.drive_low || res.busy_res))
    else $error("bus driven while idle");

  // a queued tick with room at the output yields a result next cycle
  a_queue_drains: assert property (@(posedge clk) disable iff (rst)
    (q_valid && (!res_valid || !res_stall)) |=> res_valid)
    else $error("queued request not processed");

endmodule

// ----- tb/sv/tb_one_wire_bus_master_core.sv -----
`timescale 1ns / 100ps
// tb_one_wire_bus_master_core: self-checking testbench for the 1-wire bus master core
// tick-level model of the bus sequencer, random stimulus and backpressure on both channels
// depends on owbm_pkg and one_wire_bus_master_core
module tb_one_wire_bus_master_core;
  import owbm_pkg::*;

  localparam int CLK_HALF_NS = 4;
  localparam int RESET_CYCLES = 12;
  localparam int CYCLE_LIMIT = 4000000;
  localparam int TAIL_CYCLES = 8;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int PRESSURE_TICKS = 100;
  localparam int RANDOM_PHASES = 5;
  localparam int TICKS_PER_PHASE = 55;
  localparam int NUM_REGS = 8;
  localparam int LAST_BIT = 7;
  localparam int MAX_REPORTS = 50;
  localparam logic [CFG_W-1:0] TIMING_MAX = {CFG_W{1'b1}};
  // opcodes the block treats as no command
  localparam logic [2:0] OP_UNUSED_MIN = 3'd5;
  localparam logic [2:0] OP_UNUSED_MAX = 3'd7;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cmd_valid = 1'b0;
  logic             cmd_stall;
  in_item_t         cmd = '0;
  logic             res_valid;
  logic             res_stall = 1'b0;
  out_item_t        res;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [2:0]       cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  one_wire_bus_master_core dut (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd(cmd),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res(res),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // clock
  always begin
    #CLK_HALF_NS clk = 1'b1;
    #CLK_HALF_NS clk = 1'b0;
  end

  // bus sequencer model state
  cfg_t       bus_timing;
  phase_t     bus_phase;
  int         slot_ticks;
  int         bit_pos;
  logic [7:0] shift_reg;
  logic [7:0] last_read_byte;
  logic       cmd_finished;
  out_item_t  predicted_bus_out[$];

  // bookkeeping
  int err_cnt = 0;
  int results_seen = 0;
  int ticks_sent = 0;
  int done_cnt = 0;
  int ignored_cnt = 0;
  int started_cnt[8];
  int cycle_cnt = 0;
  int burst_left = 0;
  logic hold_req = 1'b0;
  int hold_left = 0;
  int mode_left = 0;
  int stall_tick = 0;
  stall_mode_t stall_mode = STALL_NONE;

  // power-up state of the sequencer and its timing
  function automatic void model_reset();
    bus_timing.reset_low_ticks = 10'd60;
    bus_timing.presence_wait_ticks = 10'd8;
    bus_timing.reset_recovery_ticks = 10'd51;
    bus_timing.short_low_ticks = 10'd22;
    bus_timing.write_one_high_ticks = 10'd70;
    bus_timing.write_zero_low_ticks = 10'd80;
    bus_timing.read_sample_ticks = 10'd86;
    bus_timing.read_recovery_ticks = 10'd62;
    bus_phase = PH_IDLE;
    slot_ticks = 0;
    bit_pos = 0;
    shift_reg = '0;
    last_read_byte = '0;
    cmd_finished = 1'b0;
    for (int i = 0; i < 8; i++) started_cnt[i] = 0;
  endfunction

  function automatic logic [CFG_W-1:0] timing_field(cfg_t c, logic [2:0] idx);
    case (idx)
      REG_RESET_LOW:      return c.reset_low_ticks;
      REG_PRESENCE_WAIT:  return c.presence_wait_ticks;
      REG_RESET_RECOVERY: return c.reset_recovery_ticks;
      REG_SHORT_LOW:      return c.short_low_ticks;
      REG_WRITE_ONE_HIGH: return c.write_one_high_ticks;
      REG_WRITE_ZERO_LOW: return c.write_zero_low_ticks;
      REG_READ_SAMPLE:    return c.read_sample_ticks;
      REG_READ_RECOVERY:  return c.read_recovery_ticks;
      default:            return '0;
    endcase
  endfunction

  function automatic void store_timing_field(logic [2:0] idx, logic [CFG_W-1:0] v);
    case (idx)
      REG_RESET_LOW:      bus_timing.reset_low_ticks = v;
      REG_PRESENCE_WAIT:  bus_timing.presence_wait_ticks = v;
      REG_RESET_RECOVERY: bus_timing.reset_recovery_ticks = v;
      REG_SHORT_LOW:      bus_timing.short_low_ticks = v;
      REG_WRITE_ONE_HIGH: bus_timing.write_one_high_ticks = v;
      REG_WRITE_ZERO_LOW: bus_timing.write_zero_low_ticks = v;
      REG_READ_SAMPLE:    bus_timing.read_sample_ticks = v;
      REG_READ_RECOVERY:  bus_timing.read_recovery_ticks = v;
      default: ;
    endcase
  endfunction

  // ticks a phase lasts: optional floor of one, capped at the counter range
  function automatic int span_ticks(logic [CFG_W-1:0] v, logic floor_one);
    int n;
    n = int'(v);
    if (floor_one && n == 0) n = 1;
    if (n > (1 << TICK_COUNT_BITS)) n = 1 << TICK_COUNT_BITS;
    return n;
  endfunction

  function automatic int phase_span(phase_t p);
    case (p)
      PH_RST_LOW:  return span_ticks(bus_timing.reset_low_ticks, 1'b1);
      PH_RST_WAIT: return span_ticks(bus_timing.presence_wait_ticks, 1'b1);
      PH_RST_REC:  return span_ticks(bus_timing.reset_recovery_ticks, 1'b0);
      PH_W1_LOW:   return span_ticks(bus_timing.short_low_ticks, 1'b1);
      PH_W1_HIGH:  return span_ticks(bus_timing.write_one_high_ticks, 1'b0);
      PH_W0_LOW:   return span_ticks(bus_timing.write_zero_low_ticks, 1'b1);
      PH_RD_LOW:   return span_ticks(bus_timing.short_low_ticks, 1'b1);
      PH_RD_WAIT:  return span_ticks(bus_timing.read_sample_ticks, 1'b0);
      PH_RD_REC:   return span_ticks(bus_timing.read_recovery_ticks, 1'b0);
      default:     return 1;
    endcase
  endfunction

  // slot kind for the next bit to send, lsb first
  function automatic phase_t write_slot_phase();
    return shift_reg[0] ? PH_W1_LOW : PH_W0_LOW;
  endfunction

  // closing a phase: its side effects and the phase that follows
  function automatic phase_t next_phase(phase_t p, logic lvl);
    case (p)
      PH_RST_LOW:    return PH_RST_WAIT;
      PH_RST_WAIT:   return PH_RST_SAMPLE;
      PH_RST_SAMPLE: return lvl ? PH_RST_LOW : PH_RST_REC;
      PH_W1_LOW:     return PH_W1_HIGH;
      PH_W1_HIGH, PH_W0_LOW: begin
        shift_reg = shift_reg >> 1;
        if (bit_pos >= LAST_BIT) begin
          cmd_finished = 1'b1;
          return PH_IDLE;
        end
        bit_pos++;
        return write_slot_phase();
      end
      PH_RD_LOW:     return PH_RD_WAIT;
      PH_RD_WAIT:    return PH_RD_SAMPLE;
      PH_RD_SAMPLE: begin
        shift_reg = {lvl, shift_reg[7:1]};
        return PH_RD_REC;
      end
      PH_RD_REC: begin
        if (bit_pos >= LAST_BIT) begin
          last_read_byte = shift_reg;
          cmd_finished = 1'b1;
          return PH_IDLE;
        end
        bit_pos++;
        return PH_RD_LOW;
      end
      default: begin
        // reset recovery over, or nothing left to do
        cmd_finished = 1'b1;
        return PH_IDLE;
      end
    endcase
  endfunction

  // one bus tick: expected result fields, model state advanced
  function automatic out_item_t predict_bus_tick(in_item_t it);
    out_item_t o;
    phase_t p;
    int nxt;
    o = '0;
    cmd_finished = 1'b0;
    // command start, or drop while busy
    if (it.opcode >= OP_RESET && it.opcode <= OP_WAIT) begin
      if (bus_phase != PH_IDLE) begin
        o.cmd_ignored = 1'b1;
        ignored_cnt++;
      end else begin
        slot_ticks = 0;
        bit_pos = 0;
        started_cnt[it.opcode]++;
        case (it.opcode)
          OP_RESET: bus_phase = PH_RST_LOW;
          OP_WRITE: begin
            shift_reg = it.data_byte;
            bus_phase = write_slot_phase();
          end
          OP_READ: begin
            shift_reg = '0;
            bus_phase = PH_RD_LOW;
          end
          default: bus_phase = PH_WAIT_REL;
        endcase
      end
    end
    o.busy_res = (bus_phase != PH_IDLE);
    o.drive_low = (bus_phase == PH_RST_LOW) || (bus_phase == PH_W1_LOW) ||
                  (bus_phase == PH_W0_LOW) || (bus_phase == PH_RD_LOW);
    // tick count and phase advance, zero-length phases skipped
    if (bus_phase == PH_WAIT_REL) begin
      if (it.line_level) begin
        bus_phase = PH_IDLE;
        cmd_finished = 1'b1;
      end
    end else if (bus_phase != PH_IDLE) begin
      nxt = slot_ticks + 1;
      if (nxt >= phase_span(bus_phase)) begin
        slot_ticks = 0;
        p = bus_phase;
        do begin
          p = next_phase(p, it.line_level);
        end while (p != PH_IDLE && phase_span(p) == 0);
        bus_phase = p;
      end else begin
        slot_ticks = nxt;
      end
    end
    o.done_res = cmd_finished;
    o.read_byte = last_read_byte;
    if (cmd_finished) done_cnt++;
    return o;
  endfunction

  // send one request, predict it when taken, then maybe pause between bursts
  task automatic send_tick(logic [2:0] op, logic [7:0] data, logic lvl);
    in_item_t it;
    int gap;
    it.opcode = op;
    it.data_byte = data;
    it.line_level = lvl;
    cmd <= it;
    cmd_valid <= 1'b1;
    do @(posedge clk); while (cmd_stall);
    predicted_bus_out.push_back(predict_bus_tick(it));
    ticks_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300) :
                                                 $urandom_range(1, 32);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        cmd_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // line level that moves the command on at the given odds: presence low, release high
  function automatic logic steer_line(int low_pct_sample, int high_pct_wait);
    case (bus_phase)
      PH_RST_SAMPLE: return $urandom_range(0, 99) >= low_pct_sample;
      PH_WAIT_REL:   return $urandom_range(0, 99) < high_pct_wait;
      default:       return 1'($urandom_range(0, 1));
    endcase
  endfunction

  // idle ticks until the running command has finished
  task automatic drain_to_idle();
    while (bus_phase != PH_IDLE) begin
      send_tick(OP_NONE, 8'($urandom), steer_line(100, 100));
    end
  endtask

  task automatic run_command(logic [2:0] op, logic [7:0] data);
    send_tick(op, data, 1'($urandom_range(0, 1)));
    drain_to_idle();
  endtask

  // random tick: commands mostly at idle, some noise while busy
  task automatic send_random_tick();
    logic [2:0] op;
    int roll;
    roll = $urandom_range(0, 99);
    if (bus_phase == PH_IDLE) begin
      if (roll < 85) op = 3'($urandom_range(OP_RESET, OP_WAIT));
      else if (roll < 92) op = 3'($urandom_range(OP_UNUSED_MIN, OP_UNUSED_MAX));
      else op = OP_NONE;
    end else begin
      if (roll < 6) op = 3'($urandom_range(OP_RESET, OP_WAIT));
      else if (roll < 9) op = 3'($urandom_range(OP_UNUSED_MIN, OP_UNUSED_MAX));
      else op = OP_NONE;
    end
    send_tick(op, 8'($urandom), steer_line(75, 30));
  endtask

  // bus idle, every result back, pipeline empty
  task automatic settle_bus();
    drain_to_idle();
    cmd_valid <= 1'b0;
    while (predicted_bus_out.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // write all timing registers while the block is idle
  task automatic load_timing(cfg_t c);
    settle_bus();
    for (int i = 0; i < NUM_REGS; i++) begin
      cfg_index <= 3'(i);
      cfg_data <= timing_field(c, 3'(i));
      cfg_valid <= 1'b1;
      do @(posedge clk); while (!cfg_ready);
      store_timing_field(3'(i), timing_field(c, 3'(i)));
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic cfg_t uniform_timing(logic [CFG_W-1:0] v);
    cfg_t c;
    c.reset_low_ticks = v;
    c.presence_wait_ticks = v;
    c.reset_recovery_ticks = v;
    c.short_low_ticks = v;
    c.write_one_high_ticks = v;
    c.write_zero_low_ticks = v;
    c.read_sample_ticks = v;
    c.read_recovery_ticks = v;
    return c;
  endfunction

  // mostly tiny slot times so many commands finish, zero now and then
  function automatic logic [CFG_W-1:0] pick_short_ticks();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 2) return '0;
    if (roll < 8) return CFG_W'($urandom_range(1, 4));
    return CFG_W'($urandom_range(5, 24));
  endfunction

  function automatic cfg_t random_timing();
    cfg_t c;
    c.reset_low_ticks = pick_short_ticks();
    c.presence_wait_ticks = pick_short_ticks();
    c.reset_recovery_ticks = pick_short_ticks();
    c.short_low_ticks = pick_short_ticks();
    c.write_one_high_ticks = pick_short_ticks();
    c.write_zero_low_ticks = pick_short_ticks();
    c.read_sample_ticks = pick_short_ticks();
    c.read_recovery_ticks = pick_short_ticks();
    return c;
  endfunction

  // power-up timing values, never written
  task automatic test_power_up_timing();
    run_command(OP_RESET, 8'h00);
  endtask

  // zero timing: floors of one, skipped phases and the odd cases
  task automatic test_corner_cases();
    load_timing(uniform_timing('0));
    // reset that misses presence once, then sees it
    send_tick(OP_RESET, 8'h00, 1'b1);
    send_tick(OP_NONE, 8'h00, 1'b1);
    send_tick(OP_NONE, 8'h00, 1'b1);
    send_tick(OP_NONE, 8'h00, 1'b1);
    send_tick(OP_NONE, 8'h00, 1'b1);
    send_tick(OP_NONE, 8'h00, 1'b0);
    // write all ones, a read landing on the done tick
    send_tick(OP_WRITE, 8'hFF, 1'b0);
    repeat (6) send_tick(OP_NONE, 8'h00, 1'b0);
    send_tick(OP_READ, 8'h00, 1'b1);
    // read with the line high on every sample
    send_tick(OP_READ, 8'h00, 1'b1);
    repeat (15) send_tick(OP_NONE, 8'h00, 1'b1);
    // unused opcodes while idle
    send_tick(OP_UNUSED_MIN, 8'h00, 1'b1);
    send_tick(OP_UNUSED_MAX, 8'hFF, 1'b0);
    // wait with the line already high, then one held low for two ticks
    send_tick(OP_WAIT, 8'h00, 1'b1);
    send_tick(OP_WAIT, 8'h00, 1'b0);
    send_tick(OP_NONE, 8'h00, 1'b0);
    send_tick(OP_NONE, 8'h00, 1'b1);
    drain_to_idle();
  endtask

  // longest recovery time, tick counter runs up close to its top
  task automatic test_max_timing();
    cfg_t c;
    c = uniform_timing(CFG_W'(1));
    c.reset_recovery_ticks = TIMING_MAX;
    load_timing(c);
    run_command(OP_RESET, 8'h00);
    run_command(OP_WAIT, 8'h00);
  endtask

  // random traffic over several timing settings, the first with every register at one
  task automatic test_random_traffic();
    for (int k = 0; k < RANDOM_PHASES; k++) begin
      load_timing((k == 0) ? uniform_timing(CFG_W'(1)) : random_timing());
      repeat (TICKS_PER_PHASE) send_random_tick();
    end
  endtask

  // long receiver hold-off while requests keep coming
  task automatic test_backpressure();
    load_timing(random_timing());
    hold_req = 1'b1;
    repeat (PRESSURE_TICKS) send_random_tick();
  endtask

  // receiver stall: random modes plus an occasional long hold-off
  always @(posedge clk) begin
    stall_tick++;
    if (hold_req) begin
      hold_left = HOLD_OFF_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      res_stall <= 1'b1;
    end else begin
      if (mode_left <= 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 400);
      end
      mode_left--;
      case (stall_mode)
        STALL_NONE:  res_stall <= 1'b0;
        STALL_LIGHT: res_stall <= ($urandom_range(0, 7) == 0);
        STALL_HEAVY: res_stall <= ($urandom_range(0, 1) == 0);
        default:     res_stall <= ((stall_tick % 7) < 3);
      endcase
    end
  end

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      if (err_cnt < MAX_REPORTS) begin
        $display("%0t: %s mismatch on result %0d: expected %h, actual %h",
                 $time, name, results_seen, want, got);
      end
      err_cnt++;
    end
  endfunction

  // result check against the oldest prediction
  always @(posedge clk) begin : result_check
    out_item_t want;
    if (!rst && res_valid && !res_stall) begin
      if (predicted_bus_out.size() == 0) begin
        if (err_cnt < MAX_REPORTS) begin
          $display("%0t: result with no request outstanding: expected none, actual %h",
                   $time, res);
        end
        err_cnt++;
      end else begin
        want = predicted_bus_out.pop_front();
        check_field("drive_low", 8'(want.drive_low), 8'(res.drive_low));
        check_field("busy_res", 8'(want.busy_res), 8'(res.busy_res));
        check_field("done_res", 8'(want.done_res), 8'(res.done_res));
        check_field("read_byte", want.read_byte, res.read_byte);
        check_field("cmd_ignored", 8'(want.cmd_ignored), 8'(res.cmd_ignored));
      end
      results_seen++;
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("%0t: cycle limit hit, %0d results outstanding", $time,
               predicted_bus_out.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    model_reset();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_power_up_timing();
    test_corner_cases();
    test_max_timing();
    test_random_traffic();
    test_backpressure();
    settle_bus();
    $display("Ran %0d ticks in %0d cycles: %0d resets, %0d writes, %0d reads, %0d waits",
             ticks_sent, cycle_cnt, started_cnt[OP_RESET], started_cnt[OP_WRITE],
             started_cnt[OP_READ], started_cnt[OP_WAIT]);
    $display("%0d commands finished, %0d dropped while busy, %0d results checked, %0d mismatches",
             done_cnt, ignored_cnt, results_seen, err_cnt);
    if (err_cnt == 0 && predicted_bus_out.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
